[rtl/core/piq_pkg.sv]
// Shared widths, constants and types for the point-in-convex-quad block.
`timescale 1ns / 1ps
`default_nettype none

package piq_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int AREA_W    = PROD_W + 1;
  localparam int QUAD_W    = AREA_W + 1;
  localparam int PT_W      = AREA_W + 2;
  localparam int SUM_W     = PT_W + 1;
  localparam int NUM_VERT  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam int AREA_TOLERANCE = 2;
  localparam logic signed [SUM_W-1:0] TOL_POS = SUM_W'(AREA_TOLERANCE);
  localparam logic signed [SUM_W-1:0] TOL_NEG = -TOL_POS;

  // Pipeline stage indices
  localparam int NUM_STAGES = 5;
  localparam int ST_DIFF = 0;
  localparam int ST_PROD = 1;
  localparam int ST_AREA = 2;
  localparam int ST_SUM  = 3;
  localparam int ST_OUT  = 4;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/piq_cfg.sv]
// Vertex configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module piq_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wen,
  input  wire logic [piq_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [piq_pkg::COORD_W-1:0]      cfg_wdata,
  output piq_pkg::vertex_t [piq_pkg::NUM_VERT-1:0] vert
);

  localparam logic [piq_pkg::CFG_IDX_W-1:0] REG_V0_X = 3'd0;
  localparam logic [piq_pkg::CFG_IDX_W-1:0] REG_V0_Y = 3'd1;
  localparam logic [piq_pkg::CFG_IDX_W-1:0] REG_V1_X = 3'd2;
  localparam logic [piq_pkg::CFG_IDX_W-1:0] REG_V1_Y = 3'd3;
  localparam logic [piq_pkg::CFG_IDX_W-1:0] REG_V2_X = 3'd4;
  localparam logic [piq_pkg::CFG_IDX_W-1:0] REG_V2_Y = 3'd5;
  localparam logic [piq_pkg::CFG_IDX_W-1:0] REG_V3_X = 3'd6;
  localparam logic [piq_pkg::CFG_IDX_W-1:0] REG_V3_Y = 3'd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vert <= '0;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_V0_X: vert[0].x <= cfg_wdata;
        REG_V0_Y: vert[0].y <= cfg_wdata;
        REG_V1_X: vert[1].x <= cfg_wdata;
        REG_V1_Y: vert[1].y <= cfg_wdata;
        REG_V2_X: vert[2].x <= cfg_wdata;
        REG_V2_Y: vert[2].y <= cfg_wdata;
        REG_V3_X: vert[3].x <= cfg_wdata;
        REG_V3_Y: vert[3].y <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/piq_ctrl.sv]
// Valid chain and per-stage load enables of the area pipeline.
`timescale 1ns / 1ps
`default_nettype none

module piq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         m_tready,
  output piq_pkg::pipe_ctrl_t ctrl
);

  logic [piq_pkg::NUM_STAGES-1:0] valid;
  logic [piq_pkg::NUM_STAGES-1:0] en;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[piq_pkg::NUM_STAGES-1] = !valid[piq_pkg::NUM_STAGES-1] || m_tready;
    for (int i = piq_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int i = 1; i < piq_pkg::NUM_STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign ctrl.en    = en;
  assign ctrl.valid = valid;

endmodule

`default_nettype wire

[rtl/core/piq_tri_area.sv]
// One lane: doubled triangle area |cross(a - o, b - o)| in three stages.
`timescale 1ns / 1ps
`default_nettype none

module piq_tri_area (
  input  wire logic                                clk,
  input  wire piq_pkg::pipe_ctrl_t                 ctrl,
  input  wire logic signed [piq_pkg::COORD_W-1:0]  o_x,
  input  wire logic signed [piq_pkg::COORD_W-1:0]  o_y,
  input  wire logic signed [piq_pkg::COORD_W-1:0]  a_x,
  input  wire logic signed [piq_pkg::COORD_W-1:0]  a_y,
  input  wire logic signed [piq_pkg::COORD_W-1:0]  b_x,
  input  wire logic signed [piq_pkg::COORD_W-1:0]  b_y,
  output logic        [piq_pkg::AREA_W-1:0]        area
);

  logic signed [piq_pkg::DIFF_W-1:0] dax, day, dbx, dby;
  logic signed [piq_pkg::PROD_W-1:0] prod1, prod2;
  logic signed [piq_pkg::AREA_W-1:0] cross_val;

  always_ff @(posedge clk) begin
    if (ctrl.en[piq_pkg::ST_DIFF]) begin
      dax <= piq_pkg::DIFF_W'(a_x) - piq_pkg::DIFF_W'(o_x);
      day <= piq_pkg::DIFF_W'(a_y) - piq_pkg::DIFF_W'(o_y);
      dbx <= piq_pkg::DIFF_W'(b_x) - piq_pkg::DIFF_W'(o_x);
      dby <= piq_pkg::DIFF_W'(b_y) - piq_pkg::DIFF_W'(o_y);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[piq_pkg::ST_PROD]) begin
      prod1 <= piq_pkg::PROD_W'(dax) * piq_pkg::PROD_W'(dby);
      prod2 <= piq_pkg::PROD_W'(dbx) * piq_pkg::PROD_W'(day);
    end
  end

  assign cross_val = piq_pkg::AREA_W'(prod1) - piq_pkg::AREA_W'(prod2);

  always_ff @(posedge clk) begin
    if (ctrl.en[piq_pkg::ST_AREA]) begin
      area <= cross_val[piq_pkg::AREA_W-1] ? piq_pkg::AREA_W'(-cross_val)
                                           : piq_pkg::AREA_W'(cross_val);
    end
  end

endmodule

`default_nettype wire

[rtl/core/point_in_convex_quad_top.sv]
// Top level: point-in-convex-quad test over a five-stage area pipeline.
// A request accepted passes the DIFF, PROD, AREA, SUM and OUT registers before its result shows on m_tvalid.
// Throughput: one request per cycle while the output is not stalled; six triangle-area
// lanes with two 17x17 multipliers each run in parallel, one multiply stage deep.
// Reset (rst, synchronous): empties the pipeline and clears all vertices to zero.
`timescale 1ns / 1ps
`default_nettype none

module point_in_convex_quad_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [piq_pkg::IN_DATA_W-1:0]     s_tdata,  // [15:0] query_x, [31:16] query_y
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [piq_pkg::OUT_DATA_W-1:0]    m_tdata,  // [0] inside_res, [7:1] zero
  input  wire logic                              cfg_wen,
  input  wire logic [piq_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [piq_pkg::COORD_W-1:0]       cfg_wdata
);

  piq_pkg::vertex_t [piq_pkg::NUM_VERT-1:0] vert;
  piq_pkg::pipe_ctrl_t                      ctrl;

  logic signed [piq_pkg::COORD_W-1:0] query_x, query_y;
  logic [piq_pkg::AREA_W-1:0] pt_area [4];
  logic [piq_pkg::AREA_W-1:0] quad_area [2];
  logic [piq_pkg::PT_W-1:0]   pt_sum;
  logic [piq_pkg::QUAD_W-1:0] quad_sum;
  logic signed [piq_pkg::SUM_W-1:0] area_diff;
  logic inside_res;

  assign query_x = s_tdata[piq_pkg::COORD_W-1:0];
  assign query_y = s_tdata[2*piq_pkg::COORD_W-1:piq_pkg::COORD_W];

  piq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .vert      (vert)
  );

  piq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  assign s_tready = ctrl.en[piq_pkg::ST_DIFF];
  assign m_tvalid = ctrl.valid[piq_pkg::ST_OUT];

  // Quad area, split along diagonal 1-2
  piq_tri_area u_quad0 (
    .clk(clk), .ctrl(ctrl),
    .o_x(vert[2].x), .o_y(vert[2].y),
    .a_x(vert[0].x), .a_y(vert[0].y),
    .b_x(vert[1].x), .b_y(vert[1].y),
    .area(quad_area[0])
  );

  piq_tri_area u_quad1 (
    .clk(clk), .ctrl(ctrl),
    .o_x(vert[2].x), .o_y(vert[2].y),
    .a_x(vert[3].x), .a_y(vert[3].y),
    .b_x(vert[1].x), .b_y(vert[1].y),
    .area(quad_area[1])
  );

  // Point triangles on sides 0-1, 0-2, 3-1 and 3-2
  piq_tri_area u_pt01 (
    .clk(clk), .ctrl(ctrl),
    .o_x(query_x), .o_y(query_y),
    .a_x(vert[0].x), .a_y(vert[0].y),
    .b_x(vert[1].x), .b_y(vert[1].y),
    .area(pt_area[0])
  );

  piq_tri_area u_pt02 (
    .clk(clk), .ctrl(ctrl),
    .o_x(query_x), .o_y(query_y),
    .a_x(vert[0].x), .a_y(vert[0].y),
    .b_x(vert[2].x), .b_y(vert[2].y),
    .area(pt_area[1])
  );

  piq_tri_area u_pt31 (
    .clk(clk), .ctrl(ctrl),
    .o_x(query_x), .o_y(query_y),
    .a_x(vert[3].x), .a_y(vert[3].y),
    .b_x(vert[1].x), .b_y(vert[1].y),
    .area(pt_area[2])
  );

  piq_tri_area u_pt32 (
    .clk(clk), .ctrl(ctrl),
    .o_x(query_x), .o_y(query_y),
    .a_x(vert[3].x), .a_y(vert[3].y),
    .b_x(vert[2].x), .b_y(vert[2].y),
    .area(pt_area[3])
  );

  always_ff @(posedge clk) begin
    if (ctrl.en[piq_pkg::ST_SUM]) begin
      pt_sum   <= piq_pkg::PT_W'(pt_area[0]) + piq_pkg::PT_W'(pt_area[1])
                + piq_pkg::PT_W'(pt_area[2]) + piq_pkg::PT_W'(pt_area[3]);
      quad_sum <= piq_pkg::QUAD_W'(quad_area[0]) + piq_pkg::QUAD_W'(quad_area[1]);
    end
  end

  // Inside when |pt_sum - quad_sum| < tolerance
  assign area_diff  = piq_pkg::SUM_W'(pt_sum) - piq_pkg::SUM_W'(quad_sum);
  assign inside_res = (area_diff < piq_pkg::TOL_POS) && (area_diff > piq_pkg::TOL_NEG);

  always_ff @(posedge clk) begin
    if (ctrl.en[piq_pkg::ST_OUT]) begin
      m_tdata <= piq_pkg::OUT_DATA_W'(inside_res);
    end
  end

  // Full pipeline with a stalled output must refuse new requests.
  assert property (@(posedge clk) disable iff (rst)
    (&ctrl.valid && !m_tready) |-> !s_tready)
    else $error("request accepted into a full stalled pipeline");

  // A request entering an empty pipeline reaches m_tvalid after passing each stage register.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && ctrl.valid == '0) |-> ##5 m_tvalid)
    else $error("result missing five cycles after request");

  // A result sitting in the sum stage moves to the output when it has room.
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.valid[piq_pkg::ST_SUM] && ctrl.en[piq_pkg::ST_OUT]) |=> m_tvalid)
    else $error("result lost between sum stage and output");

  // An empty pipeline always takes a request.
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.valid == '0) |-> s_tready)
    else $error("empty pipeline not ready");

endmodule

`default_nettype wire
